[rtl/jev_pkg.sv]
// Shared types and constants for the 3x3 Jacobi eigenvector block.
// Used by the iterative root/divide unit and by the top level.
package jev_pkg;

   localparam int AW = 38;
   localparam logic signed [AW-1:0] A_LIMIT = 38'sd7516192768;
   localparam logic signed [AW-1:0] ONE_Q30 = 38'sd1073741824;
   localparam logic [6:0] ROT_CAP = 7'd64;

   localparam logic CSR_STOP_THRESHOLD = 1'b0;
   localparam logic CSR_MAX_ROTATIONS = 1'b1;

   typedef enum logic {ITER_SQRT, ITER_DIV} iter_op_type;

   typedef struct packed {
      logic start;
      iter_op_type op;
      logic [63:0] arg;
      logic [32:0] den;
   } iter_req_type;

   typedef struct packed {
      logic done;
      logic [31:0] result;
   } iter_rsp_type;

endpackage

[rtl/jev_req_if.sv]
// Input channel of the Jacobi eigenvector block: six symmetric matrix entries.
// Standalone; no package needed.
interface jev_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] m00;
   logic signed [31:0] m01;
   logic signed [31:0] m02;
   logic signed [31:0] m11;
   logic signed [31:0] m12;
   logic signed [31:0] m22;
   modport source(output valid, m00, m01, m02, m11, m12, m22, input ready);
   modport sink(input valid, m00, m01, m02, m11, m12, m22, output ready);
endinterface

[rtl/jev_rsp_if.sv]
// Result channel of the Jacobi eigenvector block: three eigenvectors in Q2.30.
// Standalone; no package needed.
interface jev_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] vec0_x;
   logic signed [31:0] vec0_y;
   logic signed [31:0] vec0_z;
   logic signed [31:0] vec1_x;
   logic signed [31:0] vec1_y;
   logic signed [31:0] vec1_z;
   logic signed [31:0] vec2_x;
   logic signed [31:0] vec2_y;
   logic signed [31:0] vec2_z;
   modport source(output valid, vec0_x, vec0_y, vec0_z, vec1_x, vec1_y, vec1_z,
                  vec2_x, vec2_y, vec2_z, input ready);
   modport sink(input valid, vec0_x, vec0_y, vec0_z, vec1_x, vec1_y, vec1_z,
                vec2_x, vec2_y, vec2_z, output ready);
endinterface

[rtl/jacobi_eigenvectors_3x3.sv]
// Top level of the 3x3 symmetric Jacobi eigenvector block.
// Depends on jev_pkg, jev_req_if, jev_rsp_if and jev_iter.
//
//   Channel   Direction  Beat contents
//   req_if    in         m00 m01 m02 m11 m12 m22, signed Q16.16
//   rsp_if    out        vec0..vec2 x/y/z, signed Q2.30
//   csr_*     in         write of stop_threshold or max_rotations
//
// One matrix is handled one rotation after another; the time each of its R rotations takes
// varies with the one-bit normalizing shifts. Each rotation is bound by the bit-serial
// root/divide unit: two roots of 32 steps and two divides of 62 steps, plus 21 products on
// one shared multiplier.
// The input is ready only while the block is idle; a finished result waits in an
// output register, and a later result waits for it to be taken.
// Reset is synchronous and sets stop_threshold to 1 and max_rotations to 32.
module jacobi_eigenvectors_3x3 (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [30:0] csr_wdata,
   jev_req_if.sink req_if,
   jev_rsp_if.source rsp_if
);

   typedef enum logic [3:0] {
      S_IDLE, S_SELECT, S_SCALE, S_NORM, S_SQ_A, S_SQ_B, S_ROOT1, S_DIV1,
      S_TSQ, S_ROOT2, S_DIV2, S_ROT, S_FINISH
   } state_type;

   function automatic logic signed [37:0] clamp(input logic signed [38:0] x,
                                                input logic signed [37:0] lim);
      logic signed [38:0] l;
      begin
         l = 39'(lim);
         if (x > l) return lim;
         else if (x < -l) return -lim;
         else return x[37:0];
      end
   endfunction

   function automatic logic [37:0] mag(input logic signed [37:0] x);
      return x[37] ? 38'(-x) : 38'(x);
   endfunction

   state_type state_ff;
   logic [30:0] thr_ff;
   logic [6:0] maxrot_ff;
   logic [6:0] lim_ff;
   logic [6:0] rot_ff;
   logic [2:0][37:0] dg_ff;
   logic [2:0][37:0] off_ff;
   logic [2:0][2:0][31:0] v_ff;
   logic [2:0][2:0][31:0] vout_ff;
   logic out_valid_ff;
   logic [1:0] sel_ff;
   logic signed [37:0] apq_ff;
   logic tneg_ff;
   logic [34:0] ud_ff;
   logic [34:0] ub_ff;
   logic [63:0] n_ff;
   logic [63:0] prod_ff;
   logic [30:0] tm_ff;
   logic [30:0] c_ff;
   logic signed [31:0] s_ff;
   logic [4:0] op_ff;
   logic ph_ff;
   logic signed [37:0] hold_ff;
   logic signed [37:0] newx_ff;

   jev_pkg::iter_req_type it_req;
   jev_pkg::iter_rsp_type it_rsp;

   jev_iter u_iter (.clock(clock), .reset(reset), .req(it_req), .rsp(it_rsp));

   logic [37:0] om0, om1, om2, best;
   logic [1:0] sel;
   logic [1:0] p_sel, q_sel, p_rot, q_rot, xi, yi;
   logic signed [38:0] dval;
   logic [34:0] mx;
   logic [4:0] opm2;
   logic [1:0] pr, mm, row;
   logic signed [31:0] kval;
   logic signed [37:0] xval, xsrc, ysrc;
   logic [37:0] xmag_full;
   logic [31:0] kmag_full;
   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic [64:0] rsum;
   logic signed [37:0] res;
   logic signed [37:0] lim_v;
   logic signed [37:0] ynew;
   logic [32:0] e_val;

   always_comb begin
      om0 = mag(off_ff[0]);
      om1 = mag(off_ff[1]);
      om2 = mag(off_ff[2]);
      best = om0;
      sel = 2'd0;
      if (om1 > best) begin
         best = om1;
         sel = 2'd1;
      end
      if (om2 > best) begin
         best = om2;
         sel = 2'd2;
      end
      p_sel = (sel == 2'd2) ? 2'd1 : 2'd0;
      q_sel = (sel == 2'd0) ? 2'd1 : 2'd2;
      dval = 39'(signed'(dg_ff[q_sel])) - 39'(signed'(dg_ff[p_sel]));
      p_rot = (sel_ff == 2'd2) ? 2'd1 : 2'd0;
      q_rot = (sel_ff == 2'd0) ? 2'd1 : 2'd2;
      xi = (sel_ff == 2'd0) ? 2'd1 : 2'd0;
      yi = (sel_ff == 2'd2) ? 2'd1 : 2'd2;
      mx = (ud_ff > ub_ff) ? ud_ff : ub_ff;
   end

   always_comb begin
      opm2 = op_ff - 5'd2;
      pr = opm2[3:2];
      mm = opm2[1:0];
      row = pr - 2'd1;
      if (pr == 2'd0) begin
         xsrc = off_ff[xi];
         ysrc = off_ff[yi];
      end else begin
         xsrc = 38'(signed'(v_ff[p_rot][row]));
         ysrc = 38'(signed'(v_ff[q_rot][row]));
      end
      if (op_ff == 5'd0) begin
         kval = tneg_ff ? -32'(tm_ff) : 32'(tm_ff);
         xval = 38'(c_ff);
      end else if (op_ff == 5'd1) begin
         kval = tneg_ff ? -32'(tm_ff) : 32'(tm_ff);
         xval = apq_ff;
      end else begin
         kval = (mm == 2'd0 || mm == 2'd3) ? 32'(c_ff) : s_ff;
         xval = mm[0] ? ysrc : xsrc;
      end
      xmag_full = mag(xval);
      kmag_full = kval[31] ? 32'(-kval) : 32'(kval);
      case (state_ff)
         S_SQ_A: begin
            mul_a = ph_ff ? 33'(ub_ff[31:0]) : 33'(ud_ff[31:0]);
            mul_b = ph_ff ? ub_ff[31:0] : ud_ff[31:0];
         end
         S_TSQ: begin
            mul_a = 33'(tm_ff);
            mul_b = 32'(tm_ff);
         end
         default: begin
            mul_a = xmag_full[32:0];
            mul_b = kmag_full;
         end
      endcase
      rsum = {1'b0, prod_ff} + (65'd1 << 29);
      res = (kval[31] ^ xval[37]) ? -38'(rsum[64:30]) : 38'(rsum[64:30]);
      lim_v = (pr == 2'd0) ? jev_pkg::A_LIMIT : jev_pkg::ONE_Q30;
      ynew = clamp(39'(hold_ff) + 39'(res), lim_v);
      e_val = {1'b0, ud_ff[31:0]} + {1'b0, it_rsp.result};
   end

   always_comb begin
      it_req = '0;
      case (state_ff)
         S_SQ_B: begin
            it_req.start = 1'b1;
            it_req.op = jev_pkg::ITER_SQRT;
            it_req.arg = n_ff + prod_ff;
         end
         S_ROOT1: begin
            it_req.start = it_rsp.done;
            it_req.op = jev_pkg::ITER_DIV;
            it_req.arg = (64'(ub_ff[31:0]) << 30) + 64'(e_val >> 1);
            it_req.den = e_val;
         end
         S_TSQ: begin
            it_req.start = ph_ff;
            it_req.op = jev_pkg::ITER_SQRT;
            it_req.arg = prod_ff + (64'd1 << 60);
         end
         S_ROOT2: begin
            it_req.start = it_rsp.done;
            it_req.op = jev_pkg::ITER_DIV;
            it_req.arg = (64'd1 << 60) + 64'(it_rsp.result >> 1);
            it_req.den = {1'b0, it_rsp.result};
         end
         default: it_req = '0;
      endcase
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.vec0_x = vout_ff[0][0];
   assign rsp_if.vec0_y = vout_ff[0][1];
   assign rsp_if.vec0_z = vout_ff[0][2];
   assign rsp_if.vec1_x = vout_ff[1][0];
   assign rsp_if.vec1_y = vout_ff[1][1];
   assign rsp_if.vec1_z = vout_ff[1][2];
   assign rsp_if.vec2_x = vout_ff[2][0];
   assign rsp_if.vec2_y = vout_ff[2][1];
   assign rsp_if.vec2_z = vout_ff[2][2];

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff <= 31'd1;
         maxrot_ff <= 7'd32;
         out_valid_ff <= 1'b0;
         ph_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               jev_pkg::CSR_STOP_THRESHOLD: thr_ff <= csr_wdata;
               jev_pkg::CSR_MAX_ROTATIONS: maxrot_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
         if (out_valid_ff && rsp_if.ready && state_ff != S_FINISH) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  dg_ff[0] <= 38'(req_if.m00);
                  dg_ff[1] <= 38'(req_if.m11);
                  dg_ff[2] <= 38'(req_if.m22);
                  off_ff[0] <= 38'(req_if.m01);
                  off_ff[1] <= 38'(req_if.m02);
                  off_ff[2] <= 38'(req_if.m12);
                  v_ff <= {32'(jev_pkg::ONE_Q30), 96'd0, 32'(jev_pkg::ONE_Q30), 96'd0,
                           32'(jev_pkg::ONE_Q30)};
                  lim_ff <= (maxrot_ff > jev_pkg::ROT_CAP) ? jev_pkg::ROT_CAP : maxrot_ff;
                  rot_ff <= '0;
                  state_ff <= S_SELECT;
               end
            end
            S_SELECT: begin
               if (rot_ff >= lim_ff || best == '0 || best < 38'(thr_ff)) begin
                  state_ff <= S_FINISH;
               end else begin
                  sel_ff <= sel;
                  apq_ff <= off_ff[sel];
                  tneg_ff <= (dval != '0) && (dval[38] != off_ff[sel][37]);
                  ud_ff <= dval[38] ? 35'(-dval) : 35'(dval);
                  ub_ff <= 35'(mag(off_ff[sel]) << 1);
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               if (mx >= 35'd4294967296 * 2) begin
                  ud_ff <= (ud_ff + 35'd4) >> 3;
                  ub_ff <= (ub_ff + 35'd4) >> 3;
                  state_ff <= S_SQ_A;
               end else if (mx >= 35'd4294967296) begin
                  ud_ff <= (ud_ff + 35'd2) >> 2;
                  ub_ff <= (ub_ff + 35'd2) >> 2;
                  state_ff <= S_SQ_A;
               end else if (mx >= 35'd2147483648) begin
                  ud_ff <= (ud_ff + 35'd1) >> 1;
                  ub_ff <= (ub_ff + 35'd1) >> 1;
                  state_ff <= S_SQ_A;
               end else begin
                  state_ff <= S_NORM;
               end
               ph_ff <= 1'b0;
            end
            S_NORM: begin
               if (mx < 35'd1073741824) begin
                  ud_ff <= ud_ff << 1;
                  ub_ff <= ub_ff << 1;
               end else begin
                  state_ff <= S_SQ_A;
               end
            end
            S_SQ_A: begin
               ph_ff <= ~ph_ff;
               if (ph_ff) begin
                  n_ff <= prod_ff;
                  state_ff <= S_SQ_B;
               end
            end
            S_SQ_B: state_ff <= S_ROOT1;
            S_ROOT1: if (it_rsp.done) state_ff <= S_DIV1;
            S_DIV1: begin
               if (it_rsp.done) begin
                  tm_ff <= it_rsp.result[30:0];
                  ph_ff <= 1'b0;
                  state_ff <= S_TSQ;
               end
            end
            S_TSQ: begin
               ph_ff <= ~ph_ff;
               if (ph_ff) state_ff <= S_ROOT2;
            end
            S_ROOT2: if (it_rsp.done) state_ff <= S_DIV2;
            S_DIV2: begin
               if (it_rsp.done) begin
                  c_ff <= it_rsp.result[30:0];
                  op_ff <= '0;
                  ph_ff <= 1'b0;
                  state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               ph_ff <= ~ph_ff;
               if (ph_ff) begin
                  if (op_ff == 5'd0) begin
                     s_ff <= res[31:0];
                  end else if (op_ff == 5'd1) begin
                     dg_ff[p_rot] <= clamp(39'(signed'(dg_ff[p_rot])) - 39'(res),
                                           jev_pkg::A_LIMIT);
                     dg_ff[q_rot] <= clamp(39'(signed'(dg_ff[q_rot])) + 39'(res),
                                           jev_pkg::A_LIMIT);
                     off_ff[sel_ff] <= '0;
                  end else begin
                     case (mm)
                        2'd0, 2'd2: hold_ff <= res;
                        2'd1: newx_ff <= clamp(39'(hold_ff) - 39'(res), lim_v);
                        default: begin
                           if (pr == 2'd0) begin
                              off_ff[xi] <= newx_ff;
                              off_ff[yi] <= ynew;
                           end else begin
                              v_ff[p_rot][row] <= newx_ff[31:0];
                              v_ff[q_rot][row] <= ynew[31:0];
                           end
                        end
                     endcase
                  end
                  if (op_ff == 5'd17) begin
                     rot_ff <= rot_ff + 7'd1;
                     state_ff <= S_SELECT;
                  end else begin
                     op_ff <= op_ff + 5'd1;
                  end
               end
            end
            S_FINISH: begin
               if (!out_valid_ff || rsp_if.ready) begin
                  vout_ff <= v_ff;
                  out_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/jev_iter.sv]
// Bit-serial unit for a rounded 64-bit square root and a 62-by-33-bit divide.
// Depends on jev_pkg for the request and response structs.
module jev_iter (
   input  logic clock,
   input  logic reset,
   input  jev_pkg::iter_req_type req,
   output jev_pkg::iter_rsp_type rsp
);

   logic busy_ff;
   logic done_ff;
   jev_pkg::iter_op_type op_ff;
   logic [5:0] cnt_ff;
   logic [63:0] rem_ff;
   logic [63:0] acc_ff;
   logic [63:0] aux_ff;
   logic [32:0] den_ff;

   logic [63:0] trial;
   logic [33:0] rem2;
   logic [63:0] root_rnd;

   assign trial = acc_ff + aux_ff;
   assign rem2 = {rem_ff[32:0], aux_ff[61]};
   assign root_rnd = acc_ff + 64'(rem_ff > acc_ff);
   assign rsp.done = done_ff;
   assign rsp.result = (op_ff == jev_pkg::ITER_SQRT) ? root_rnd[31:0] : acc_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff && req.start) begin
            busy_ff <= 1'b1;
            op_ff <= req.op;
            acc_ff <= '0;
            den_ff <= req.den;
            if (req.op == jev_pkg::ITER_SQRT) begin
               rem_ff <= req.arg;
               aux_ff <= 64'd1 << 62;
               cnt_ff <= 6'd31;
            end else begin
               rem_ff <= '0;
               aux_ff <= req.arg;
               cnt_ff <= 6'd61;
            end
         end else if (busy_ff) begin
            if (op_ff == jev_pkg::ITER_SQRT) begin
               if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
                  acc_ff <= (acc_ff >> 1) + aux_ff;
               end else begin
                  acc_ff <= acc_ff >> 1;
               end
               aux_ff <= aux_ff >> 2;
            end else begin
               if (rem2 >= {1'b0, den_ff}) begin
                  rem_ff <= 64'(rem2 - {1'b0, den_ff});
                  acc_ff <= {acc_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= 64'(rem2);
                  acc_ff <= {acc_ff[62:0], 1'b0};
               end
               aux_ff <= aux_ff << 1;
            end
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

endmodule

[verif/jacobi_eigenvectors_3x3_tb.sv]
// Testbench for the 3x3 symmetric Jacobi eigenvector block: drives matrices,
// predicts each eigenvector set in fixed point and compares every result beat.
// Depends on jev_pkg, jev_req_if, jev_rsp_if and the jacobi_eigenvectors_3x3 RTL.
`timescale 1ns / 100ps

module jacobi_eigenvectors_3x3_tb;

   typedef struct packed {
      logic signed [31:0] m00, m01, m02, m11, m12, m22;
   } matrix_type;

   typedef struct packed {
      logic signed [31:0] v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z;
   } vectors_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = jev_pkg::CSR_STOP_THRESHOLD;
   logic [30:0] csr_wdata = '0;

   jev_req_if req_if ();
   jev_rsp_if rsp_if ();

   jacobi_eigenvectors_3x3 uut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   always #1 clock = ~clock;

   logic [30:0] threshold_q = 31'd1;
   logic [6:0] rotations_q = 7'd32;
   vectors_type expected_vectors[$];
   int errors = 0;
   int matrices_sent = 0;
   int vectors_seen = 0;
   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int hold_cycles = 0;

   initial begin
      req_if.valid = 1'b0;
      req_if.m00 = '0; req_if.m01 = '0; req_if.m02 = '0;
      req_if.m11 = '0; req_if.m12 = '0; req_if.m22 = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic logic [63:0] magnitude(logic signed [63:0] x);
      return x < 0 ? -x : x;
   endfunction

   function automatic logic signed [63:0] saturate(logic signed [63:0] x,
                                                   logic signed [63:0] lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   function automatic logic signed [63:0] mul_q30(logic signed [63:0] k,
                                                  logic signed [63:0] x);
      logic [63:0] m;
      m = (magnitude(k) * magnitude(x) + 64'd536870912) >> 30;
      return ((k < 0) != (x < 0)) ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [63:0] root_nearest(logic [63:0] n);
      logic [63:0] r, bitv, rem;
      r = 0; bitv = 64'd1 << 62; rem = n;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= r + bitv) begin
            rem -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      if (n - r * r > r) r++;
      return r;
   endfunction

   function automatic vectors_type eigenvectors(matrix_type m);
      logic signed [63:0] a[3][3], v[3][3];
      logic signed [63:0] apq, d, b, t, c, s, tq, arp, arq, vp, vq;
      logic [63:0] best, ud, ub, mx, e, tm, u;
      int limit, p, q, r, k;
      vectors_type res;
      limit = (rotations_q > 7'd64) ? 64 : int'(rotations_q);
      a[0][0] = 64'(m.m00); a[0][1] = 64'(m.m01); a[1][0] = 64'(m.m01);
      a[0][2] = 64'(m.m02); a[2][0] = 64'(m.m02); a[1][1] = 64'(m.m11);
      a[1][2] = 64'(m.m12); a[2][1] = 64'(m.m12); a[2][2] = 64'(m.m22);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) v[i][j] = (i == j) ? 64'sd1073741824 : 64'sd0;
      for (int it = 0; it < limit; it++) begin
         p = 0; q = 1; best = magnitude(a[0][1]);
         if (magnitude(a[0][2]) > best) begin best = magnitude(a[0][2]); q = 2; end
         if (magnitude(a[1][2]) > best) begin
            best = magnitude(a[1][2]); p = 1; q = 2;
         end
         if (best == 0 || best < threshold_q) break;
         r = 3 - p - q;
         apq = a[p][q]; d = a[q][q] - a[p][p]; b = 2 * apq;
         ud = magnitude(d); ub = magnitude(b); mx = ud > ub ? ud : ub;
         if (mx >= 64'd2147483648) begin
            k = 0;
            while ((mx >> k) >= 64'd2147483648) k++;
            ud = (ud + (64'd1 << (k - 1))) >> k;
            ub = (ub + (64'd1 << (k - 1))) >> k;
         end else begin
            while (mx < 64'd1073741824) begin mx <<= 1; ud <<= 1; ub <<= 1; end
         end
         e = ud + root_nearest(ud * ud + ub * ub);
         tm = ((ub << 30) + e / 2) / e;
         t = (d != 0 && ((d < 0) != (b < 0))) ? -$signed(tm) : $signed(tm);
         u = root_nearest(tm * tm + (64'd1 << 60));
         c = $signed(((64'd1 << 60) + u / 2) / u);
         s = mul_q30(t, c);
         tq = mul_q30(t, apq);
         a[p][p] = saturate(a[p][p] - tq, jev_pkg::A_LIMIT);
         a[q][q] = saturate(a[q][q] + tq, jev_pkg::A_LIMIT);
         a[p][q] = 0; a[q][p] = 0;
         arp = a[r][p]; arq = a[r][q];
         a[r][p] = saturate(mul_q30(c, arp) - mul_q30(s, arq), jev_pkg::A_LIMIT);
         a[p][r] = a[r][p];
         a[r][q] = saturate(mul_q30(s, arp) + mul_q30(c, arq), jev_pkg::A_LIMIT);
         a[q][r] = a[r][q];
         for (int i = 0; i < 3; i++) begin
            vp = v[i][p]; vq = v[i][q];
            v[i][p] = saturate(mul_q30(c, vp) - mul_q30(s, vq), jev_pkg::ONE_Q30);
            v[i][q] = saturate(mul_q30(s, vp) + mul_q30(c, vq), jev_pkg::ONE_Q30);
         end
      end
      res.v0x = v[0][0][31:0]; res.v0y = v[1][0][31:0]; res.v0z = v[2][0][31:0];
      res.v1x = v[0][1][31:0]; res.v1y = v[1][1][31:0]; res.v1z = v[2][1][31:0];
      res.v2x = v[0][2][31:0]; res.v2y = v[1][2][31:0]; res.v2z = v[2][2][31:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   task automatic send_matrix(matrix_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      {req_if.m00, req_if.m01, req_if.m02, req_if.m11, req_if.m12, req_if.m22} <= m;
      expected_vectors.push_back(eigenvectors(m));
      matrices_sent++;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      vectors_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.vec0_x, rsp_if.vec0_y, rsp_if.vec0_z, rsp_if.vec1_x,
                rsp_if.vec1_y, rsp_if.vec1_z, rsp_if.vec2_x, rsp_if.vec2_y,
                rsp_if.vec2_z};
         vectors_seen++;
         if (expected_vectors.size() == 0) begin
            errors++;
            $display("MISMATCH unexpected result beat at %0t", $realtime);
         end else begin
            want = expected_vectors.pop_front();
            if (got.v0x !== want.v0x) report_mismatch("vec0_x", got.v0x, want.v0x);
            if (got.v0y !== want.v0y) report_mismatch("vec0_y", got.v0y, want.v0y);
            if (got.v0z !== want.v0z) report_mismatch("vec0_z", got.v0z, want.v0z);
            if (got.v1x !== want.v1x) report_mismatch("vec1_x", got.v1x, want.v1x);
            if (got.v1y !== want.v1y) report_mismatch("vec1_y", got.v1y, want.v1y);
            if (got.v1z !== want.v1z) report_mismatch("vec1_z", got.v1z, want.v1z);
            if (got.v2x !== want.v2x) report_mismatch("vec2_x", got.v2x, want.v2x);
            if (got.v2y !== want.v2y) report_mismatch("vec2_y", got.v2y, want.v2y);
            if (got.v2z !== want.v2z) report_mismatch("vec2_z", got.v2z, want.v2z);
         end
      end
   end

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_vectors.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [30:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == jev_pkg::CSR_STOP_THRESHOLD) threshold_q = value;
      else rotations_q = value[6:0];
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_entry();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3: return $signed($urandom_range(4095)) - 2048;
         default: return $signed($urandom_range(32'h00ffffff)) - 32'sh00800000;
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      m.m00 = random_entry(); m.m11 = random_entry(); m.m22 = random_entry();
      m.m01 = random_entry(); m.m02 = random_entry(); m.m12 = random_entry();
      case ($urandom_range(7))
         0: m.m01 = 0;
         1: begin m.m01 = 0; m.m02 = 0; m.m12 = 0; end
         2: begin m.m02 = m.m01; m.m12 = m.m01; end
         3: m.m11 = m.m00;
         default: ;
      endcase
      return m;
   endfunction

   task automatic test_directed();
      send_matrix('0);
      send_matrix({32'sd65536, 32'sd0, 32'sd0, 32'sd131072, 32'sd0, 32'sd196608});
      send_matrix({32'sd65536, 32'sd65536, 32'sd0, 32'sd65536, 32'sd0, 32'sd0});
      send_matrix({32'sd0, 32'sd100, 32'sd100, 32'sd0, 32'sd100, 32'sd0});
      send_matrix({32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
      send_matrix({32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'sh80000000, 32'sh80000000, 32'sh80000000});
      send_matrix({32'sh7fffffff, 32'sh80000000, 32'sd1, 32'sh80000000,
                   -32'sd1, 32'sh7fffffff});
      send_matrix({32'sd0, -32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd5});
      send_matrix({32'sd3, 32'sd0, 32'sd0, -32'sd7, 32'sd1, 32'sd2});
      send_matrix({-32'sd65536, 32'sd0, -32'sd4096, 32'sd0, 32'sd0, 32'sd65536});
      wait_drained();
   endtask

   task automatic test_settings();
      write_csr(jev_pkg::CSR_MAX_ROTATIONS, 31'd0);
      send_matrix({32'sd10, 32'sd20, 32'sd30, 32'sd40, 32'sd50, 32'sd60});
      wait_drained();
      write_csr(jev_pkg::CSR_MAX_ROTATIONS, 31'd1);
      write_csr(jev_pkg::CSR_STOP_THRESHOLD, 31'd0);
      send_matrix({32'sd10, 32'sd20, 32'sd30, 32'sd40, 32'sd50, 32'sd60});
      send_matrix('0);
      wait_drained();
      write_csr(jev_pkg::CSR_MAX_ROTATIONS, 31'd127);
      write_csr(jev_pkg::CSR_STOP_THRESHOLD, 31'h7fffffff);
      send_matrix({32'sd10, 32'sh7ffff000, 32'sd30, 32'sd40, 32'sd50, 32'sd60});
      wait_drained();
      write_csr(jev_pkg::CSR_STOP_THRESHOLD, 31'd65536);
      write_csr(jev_pkg::CSR_MAX_ROTATIONS, 31'd64);
      send_matrix({32'sd10, 32'sd70000, 32'sd30, 32'sd40, 32'sd50, 32'sd60});
      wait_drained();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            wait_drained();
            write_csr(jev_pkg::CSR_MAX_ROTATIONS,
                      31'($urandom_range(3) == 0 ? $urandom_range(127)
                                                 : $urandom_range(1, 8)));
            write_csr(jev_pkg::CSR_STOP_THRESHOLD,
                      31'($urandom_range(2) == 0 ? $urandom : $urandom_range(70000)));
         end
         send_matrix(random_matrix());
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      write_csr(jev_pkg::CSR_MAX_ROTATIONS, 31'd1);
      hold_cycles = 3000;
      for (int n = 0; n < 4; n++) send_matrix(random_matrix());
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      send_idle_pct = 21; take_idle_pct = 65;
      test_random(100);
      test_backpressure();
      send_idle_pct = 65; take_idle_pct = 21;
      test_random(100);
      send_idle_pct = 0; take_idle_pct = 0;
      write_csr(jev_pkg::CSR_MAX_ROTATIONS, 31'd32);
      write_csr(jev_pkg::CSR_STOP_THRESHOLD, 31'd1);
      test_random(100);
      $display("Sent %0d matrices, checked %0d eigenvector sets, across rotation",
               matrices_sent, vectors_seen);
      $display("limits 0 to 127, thresholds 0 to max, with input and output stalls.");
      if (errors == 0) $display("jacobi_eigenvectors_3x3_tb passed");
      else $display("jacobi_eigenvectors_3x3_tb failed");
      $finish;
   end

   initial begin
      #100000000;
      $display("jacobi_eigenvectors_3x3_tb failed");
      $finish;
   end

endmodule
